// ===== rtl/core/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, character codes and per-line scan functions for the scanner.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int OFFSET_BITS = 20;
  localparam int LINE_BITS   = 20;
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [LINE_BITS-1:0]   line_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;

  localparam off_t OFF_ONE = off_t'(1);

  typedef enum logic [1:0] {
    KIND_BARE   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NO_LT    = 3'd1,
    ERR_NO_GT    = 3'd2,
    ERR_NO_KEY   = 3'd3,
    ERR_TRAILING = 3'd4,
    ERR_OVERFLOW = 3'd5
  } err_t;

  typedef struct packed {
    logic  lead_done;
    logic  text_seen;
    logic  first_slash;
    logic  skip;
    logic  is_tagged;
    logic  suffix_slash;
    logic  suffix_ok;
    line_t indent;
    off_t  text_start;
    off_t  text_end;
    off_t  mark_lt;
    off_t  mark_gt;
    off_t  key_start;
    off_t  key_end;
    off_t  suf_start;
    off_t  note_start;
  } line_state_t;

  typedef struct packed {
    kind_t kind;
    err_t  err;
    line_t line;
    line_t indent;
    off_t  main_start;
    off_t  main_end;
    off_t  value_start;
    off_t  value_end;
    off_t  note_start;
    off_t  note_end;
    logic  done;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic    valid;
    logic    is_err;
    result_t res;
  } finish_t;

  function automatic result_t error_result(err_t code, line_t line);
    result_t r;
    r        = '0;
    r.kind   = KIND_ERROR;
    r.err    = code;
    r.line   = line;
    r.done   = 1'b1;
    return r;
  endfunction

  function automatic line_state_t take_byte(line_state_t s, logic [7:0] b, off_t p);
    line_state_t t;
    logic        tsp;
    t   = s;
    tsp = (b == CH_SP) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
    if (!s.lead_done && ((b == CH_SP) || (b == CH_TAB))) begin
      t.indent = s.indent + line_t'(1);
    end else begin
      t.lead_done = 1'b1;
      if (!tsp) begin
        if (!s.text_seen) begin
          t.text_seen   = 1'b1;
          t.text_start  = p;
          t.text_end    = p + OFF_ONE;
          t.is_tagged   = (b == CH_HASH);
          t.first_slash = (b == CH_SLASH);
        end else begin
          t.text_end = p + OFF_ONE;
          if (s.first_slash && (p == s.text_start + OFF_ONE) && (b == CH_SLASH))
            t.skip = 1'b1;
          if (s.is_tagged) begin
            if (s.mark_lt == '0) begin
              if (b == CH_LT) begin
                t.mark_lt = p;
              end else begin
                if (s.key_start == '0) t.key_start = p;
                t.key_end = p + OFF_ONE;
              end
            end else if (s.mark_gt == '0) begin
              if (b == CH_GT) t.mark_gt = p;
            end else if (s.suf_start == '0) begin
              t.suf_start = p;
              if (b == CH_SLASH) t.suffix_slash = 1'b1;
            end else if (p == s.suf_start + OFF_ONE) begin
              if (s.suffix_slash && (b == CH_SLASH)) t.suffix_ok = 1'b1;
            end else if (s.suffix_ok && (s.note_start == '0)) begin
              t.note_start = p;
            end
          end
        end
      end
    end
    return t;
  endfunction

  function automatic finish_t finish_line(line_state_t s, line_t line);
    finish_t f;
    err_t    e;
    f     = '0;
    e     = ERR_NONE;
    f.valid = s.text_seen && !s.skip;
    if (!s.is_tagged) begin
      f.res.kind       = KIND_BARE;
      f.res.line       = line;
      f.res.indent     = s.indent;
      f.res.main_start = s.text_start;
      f.res.main_end   = s.text_end;
    end else begin
      if (s.mark_lt == '0)                          e = ERR_NO_LT;
      else if (s.mark_gt == '0)                     e = ERR_NO_GT;
      else if (s.key_start == '0)                   e = ERR_NO_KEY;
      else if ((s.suf_start != '0) && !s.suffix_ok) e = ERR_TRAILING;
      if (e != ERR_NONE) begin
        f.is_err = f.valid;
        f.res    = error_result(e, line);
      end else begin
        f.res.kind        = KIND_RECORD;
        f.res.line        = line;
        f.res.indent      = s.indent;
        f.res.main_start  = s.key_start;
        f.res.main_end    = s.key_end;
        f.res.value_start = s.mark_lt + OFF_ONE;
        f.res.value_end   = s.mark_gt;
        if (s.note_start != '0) begin
          f.res.note_start = s.note_start;
          f.res.note_end   = s.text_end;
        end else begin
          f.res.note_start = s.mark_gt + OFF_ONE;
          f.res.note_end   = s.mark_gt + OFF_ONE;
        end
      end
    end
    return f;
  endfunction

endpackage

// ===== rtl/core/tagged_text_line_scanner.sv =====
// ----------------------------------------------------------------------------
// tagged_text_line_scanner
// Splits a byte stream into lines and reports bare lines, tagged records, errors and document ends.
// ----------------------------------------------------------------------------
// Input stream: one text byte per word on s_tdata, s_tlast marks the last
// byte of a document. Output stream: one result per word; m_tuser carries
// kind and error code, m_tdata the line number, indent and offset spans,
// m_tlast is set on the document-end or error result.
// A byte is taken every cycle while the four-entry result queue has room;
// a byte that ends a line or a document queues its results in that cycle.
// Results are registered in the queue before they reach the output. Each
// queue entry holds up to two results and drains at one word per cycle
// while the receiver is ready, so a byte with two results takes two words.
// When the receiver stalls, results wait in the queue and bytes keep being
// taken until the queue is full; s_tready then drops.
// Reset (rst, synchronous) empties the queue and returns to the start of a
// document at line one, offset zero.
// ----------------------------------------------------------------------------
module tagged_text_line_scanner (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // text_byte
  input  logic         s_tlast,   // final_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // line_num, indent_width, main_start, main_end,
                                  // value_start, value_end, note_start, note_end
  output logic [4:0]   m_tuser,   // line_kind, error_code
  output logic         m_tlast    // document_done
);
  import tts_pkg::*;

  logic   take, push, pop, full, empty;
  entry_t push_entry, head;

  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;

  tts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .text_byte  (s_tdata),
    .final_byte (s_tlast),
    .push       (push),
    .push_entry (push_entry)
  );

  tts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  tts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== rtl/core/tts_front.sv =====
// ----------------------------------------------------------------------------
// tts_front
// Accepts text bytes, tracks line state and builds up to two results a byte.
// ----------------------------------------------------------------------------
module tts_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      text_byte,
  input  logic            final_byte,
  output logic            push,
  output tts_pkg::entry_t push_entry
);
  import tts_pkg::*;

  line_state_t st, st_next;
  off_t        byte_offset, byte_offset_next;
  line_t       current_line, current_line_next;
  logic        cr_pend, cr_pend_next;
  logic        swallow, swallow_next;

  logic        is_term, is_crlf;
  line_state_t line_st;
  finish_t     fr;
  logic        do_finish, line_err;
  logic        n0, n1;
  result_t     r0, r1, done_res;

  always_comb begin
    is_crlf   = (text_byte == CH_LF) && cr_pend;
    is_term   = !is_crlf && ((text_byte == CH_CR) || (text_byte == CH_LF));
    line_st   = (is_term || is_crlf) ? st : take_byte(st, text_byte, byte_offset);
    do_finish = is_term || final_byte;
    fr        = finish_line(line_st, current_line);
    line_err  = do_finish && fr.is_err;

    done_res      = '0;
    done_res.kind = KIND_DONE;
    done_res.line = is_term ? current_line + line_t'(1) : current_line;
    done_res.done = 1'b1;

    st_next           = st;
    byte_offset_next  = byte_offset;
    current_line_next = current_line;
    cr_pend_next      = cr_pend;
    swallow_next      = swallow;
    n0 = 1'b0;
    n1 = 1'b0;
    r0 = fr.res;
    r1 = done_res;

    if (swallow) begin
      if (final_byte) begin
        st_next           = '0;
        byte_offset_next  = '0;
        current_line_next = line_t'(1);
        cr_pend_next      = 1'b0;
        swallow_next      = 1'b0;
      end
    end else if (&byte_offset) begin
      n0 = 1'b1;
      r0 = error_result(ERR_OVERFLOW, current_line);
      if (final_byte) begin
        st_next           = '0;
        byte_offset_next  = '0;
        current_line_next = line_t'(1);
        cr_pend_next      = 1'b0;
      end else begin
        swallow_next = 1'b1;
      end
    end else begin
      n0 = do_finish && fr.valid;
      if (line_err || final_byte) begin
        st_next           = '0;
        byte_offset_next  = '0;
        current_line_next = line_t'(1);
        cr_pend_next      = 1'b0;
        swallow_next      = line_err && !final_byte;
        if (!line_err) begin
          if (n0) n1 = 1'b1;
          else begin
            n0 = 1'b1;
            r0 = done_res;
          end
        end
      end else begin
        byte_offset_next = byte_offset + OFF_ONE;
        cr_pend_next     = is_term && (text_byte == CH_CR);
        if (is_term) begin
          st_next           = '0;
          current_line_next = current_line + line_t'(1);
        end else begin
          st_next = line_st;
        end
      end
    end
  end

  assign push           = take && n0;
  assign push_entry.two = n1;
  assign push_entry.r0  = r0;
  assign push_entry.r1  = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= '0;
      byte_offset  <= '0;
      current_line <= line_t'(1);
      cr_pend      <= 1'b0;
      swallow      <= 1'b0;
    end else if (take) begin
      st           <= st_next;
      byte_offset  <= byte_offset_next;
      current_line <= current_line_next;
      cr_pend      <= cr_pend_next;
      swallow      <= swallow_next;
    end
  end

endmodule

// ===== rtl/core/tts_queue.sv =====
// ----------------------------------------------------------------------------
// tts_queue
// Short result queue between the scanning front and the output back.
// ----------------------------------------------------------------------------
module tts_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tts_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output tts_pkg::entry_t head
);
  import tts_pkg::*;

  entry_t                mem [QDEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0]  count;

  assign full  = (count == QCNT_BITS'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      if (push && !pop)      count <= count + QCNT_BITS'(1);
      else if (pop && !push) count <= count - QCNT_BITS'(1);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + QCNT_BITS'(1))
    else $error("queue count lost a word");

endmodule

// ===== rtl/core/tts_back.sv =====
// ----------------------------------------------------------------------------
// tts_back
// Drains queue entries onto the output stream, one result per word.
// ----------------------------------------------------------------------------
module tts_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  tts_pkg::entry_t  head,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [159:0]     m_tdata,   // line_num, indent_width, main_start, main_end,
                                      // value_start, value_end, note_start, note_end
  output logic [4:0]       m_tuser,   // line_kind, error_code
  output logic             m_tlast    // document_done
);
  import tts_pkg::*;

  logic    second;
  result_t cur;

  assign cur      = second ? head.r1 : head.r0;
  assign m_tvalid = !empty;
  assign pop      = m_tvalid && m_tready && (second || !head.two);
  assign m_tdata  = {cur.note_end, cur.note_start, cur.value_end, cur.value_start,
                     cur.main_end, cur.main_start, cur.indent, cur.line};
  assign m_tuser  = {cur.err, cur.kind};
  assign m_tlast  = cur.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      second <= !second && head.two;
    end
  end

endmodule
